/* src/dthp_pkg.sv */
// Shared types and constants for the drift-tube hit projection block.
`timescale 1ns / 1ps

package dthp_pkg;

   localparam int Q_W        = 44;  // 2^32 + tu^2
   localparam int ROOT_W     = 32;
   localparam int CU_W       = 31;  // cosU, Q.30
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;

   typedef struct packed {
      logic signed [26:0] du;
      logic signed [22:0] tu;
      logic signed [15:0] ca;
      logic signed [15:0] sa;
      logic signed [27:0] part;
      logic signed [1:0]  k;
   } side_type;

endpackage

/* src/drift_tube_hit_projection.sv */
// Top level: drift-tube hit residual and projection row, fully pipelined.
`timescale 1ns / 1ps

// Takes one hit beat per clock unless stalled and returns one result beat per
// hit, in order. The pipeline has 3 front stages (projections, tu/du, tu^2 and the
// drift correction), 32 square-root stages and 31 reciprocal-divide stages
// (one result bit per stage each), then 7 stages of products for the
// residual and the projection row. The output register holds a result while
// rsp_ready is low; the whole pipeline stalls with it.

module drift_tube_hit_projection (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [23:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_straw_x,
   input  logic signed [23:0] req_straw_y,
   input  logic signed [15:0] req_cos_stereo,
   input  logic signed [15:0] req_sin_stereo,
   input  logic        [22:0] req_wire_len,
   input  logic signed [23:0] req_track_x,
   input  logic signed [23:0] req_track_y,
   input  logic signed [20:0] req_ref_slope_x,
   input  logic signed [20:0] req_ref_slope_y,
   input  logic signed [23:0] req_drift_measure,
   input  logic signed [1:0]  req_side,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_residual,
   output logic signed [15:0] rsp_h_pos_x,
   output logic signed [15:0] rsp_h_pos_y,
   output logic signed [23:0] rsp_h_slope_x,
   output logic signed [23:0] rsp_h_slope_y
);

   typedef struct packed {
      logic signed [36:0] ptx;
      logic signed [36:0] pty;
      logic signed [40:0] pdx;
      logic signed [40:0] pdy;
      logic signed [24:0] d;
      logic signed [15:0] ca;
      logic signed [15:0] sa;
      logic signed [23:0] meas;
      logic signed [1:0]  amb;
      logic signed [1:0]  sgy;
   } s1_type;

   typedef struct packed {
      logic signed [22:0] tu;
      logic signed [26:0] du;
      logic signed [49:0] corrp;
      logic signed [15:0] ca;
      logic signed [15:0] sa;
      logic signed [23:0] meas;
      logic signed [1:0]  amb;
      logic signed [1:0]  k;
   } s2_type;

   typedef struct packed {
      logic [dthp_pkg::Q_W-1:0] q;
      dthp_pkg::side_type       side;
   } s3_type;

   typedef struct packed {
      logic [61:0]        cu2p;
      logic signed [57:0] wdp;
      logic signed [47:0] hxp;
      logic signed [47:0] hyp;
      logic [30:0]        cu;
      logic signed [22:0] tu;
      logic signed [26:0] du;
      logic signed [15:0] ca;
      logic signed [15:0] sa;
      logic signed [27:0] part;
   } r1_type;

   typedef struct packed {
      logic [61:0]        cu3p;
      logic signed [22:0] tu;
      logic signed [26:0] du;
      logic signed [15:0] ca;
      logic signed [15:0] sa;
      logic signed [23:0] res;
      logic signed [15:0] hx;
      logic signed [15:0] hy;
   } r2_type;

   typedef struct packed {
      logic signed [53:0] tucp;
      logic signed [26:0] du;
      logic signed [15:0] ca;
      logic signed [15:0] sa;
      logic signed [23:0] res;
      logic signed [15:0] hx;
      logic signed [15:0] hy;
   } r3_type;

   typedef struct packed {
      logic signed [45:0] pplo;
      logic signed [46:0] pphi;
      logic signed [15:0] ca;
      logic signed [15:0] sa;
      logic signed [23:0] res;
      logic signed [15:0] hx;
      logic signed [15:0] hy;
   } r4_type;

   typedef struct packed {
      logic signed [33:0] t;
      logic signed [15:0] ca;
      logic signed [15:0] sa;
      logic signed [23:0] res;
      logic signed [15:0] hx;
      logic signed [15:0] hy;
   } r5_type;

   typedef struct packed {
      logic signed [49:0] htxp;
      logic signed [49:0] htyp;
      logic signed [23:0] res;
      logic signed [15:0] hx;
      logic signed [15:0] hy;
   } r6_type;

   typedef struct packed {
      logic signed [23:0] res;
      logic signed [15:0] hx;
      logic signed [15:0] hy;
      logic signed [23:0] htx;
      logic signed [23:0] hty;
   } r7_type;

   function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
      if (v > 64'sd8388607) begin
         return 24'sh7fffff;
      end else if (v < -64'sd8388608) begin
         return 24'sh800000;
      end
      return 24'(v);
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      if (v > 64'sd32767) begin
         return 16'sh7fff;
      end else if (v < -64'sd32768) begin
         return 16'sh8000;
      end
      return 16'(v);
   endfunction

   logic        adv;
   logic [23:0] csr_delay_ratio_ff;
   logic        front_vld_ff [0:2];
   logic        back_vld_ff  [0:6];

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   r1_type r1_in, r1_ff;
   r2_type r2_in, r2_ff;
   r3_type r3_in, r3_ff;
   r4_type r4_in, r4_ff;
   r5_type r5_in, r5_ff;
   r6_type r6_in, r6_ff;
   r7_type r7_in, r7_ff;

   logic                      rc_valid;
   logic [dthp_pkg::CU_W-1:0] rc_cu;
   dthp_pkg::side_type        rc_side;

   logic [23:0]        abs_y;
   logic signed [24:0] dx, dy;
   logic signed [45:0] tu2;
   logic signed [25:0] corr;
   logic signed [26:0] diff;
   logic signed [31:0] cus;
   logic signed [47:0] rterm;
   logic [30:0]        cu2, cu3;
   logic signed [37:0] tuc;
   logic signed [63:0] tp;

   assign adv       = !back_vld_ff[6] || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_delay_ratio_ff <= '0;
      end else if (csr_wr_en) begin
         csr_delay_ratio_ff <= csr_wr_data;
      end
   end

   // front: projections
   always_comb begin
      abs_y      = req_track_y[23] ? 24'(-25'(req_track_y)) : 24'(req_track_y);
      dx         = 25'(req_track_x) - 25'(req_straw_x);
      dy         = 25'(req_track_y) - 25'(req_straw_y);
      s1_in.ptx  = 37'(req_ref_slope_x) * 37'(req_cos_stereo);
      s1_in.pty  = 37'(req_ref_slope_y) * 37'(req_sin_stereo);
      s1_in.pdx  = 41'(dx) * 41'(req_cos_stereo);
      s1_in.pdy  = 41'(dy) * 41'(req_sin_stereo);
      s1_in.d    = $signed({2'b00, req_wire_len}) - $signed({1'b0, abs_y});
      s1_in.ca   = req_cos_stereo;
      s1_in.sa   = req_sin_stereo;
      s1_in.meas = req_drift_measure;
      s1_in.amb  = req_side[1] ? -2'sd1 : (req_side[0] ? 2'sd1 : 2'sd0);
      s1_in.sgy  = req_track_y[23] ? -2'sd1 : ((req_track_y != 24'sd0) ? 2'sd1 : 2'sd0);
   end

   always_comb begin
      s2_in.tu    = 23'((64'(s1_ff.ptx) + 64'(s1_ff.pty) + 64'sd16384) >>> 15);
      s2_in.du    = 27'((64'(s1_ff.pdx) + 64'(s1_ff.pdy) + 64'sd16384) >>> 15);
      s2_in.corrp = 50'(s1_ff.d) * 50'($signed({1'b0, csr_delay_ratio_ff}));
      s2_in.ca    = s1_ff.ca;
      s2_in.sa    = s1_ff.sa;
      s2_in.meas  = s1_ff.meas;
      s2_in.amb   = s1_ff.amb;
      if (s1_ff.amb == 2'sd0 || s1_ff.sgy == 2'sd0) begin
         s2_in.k = 2'sd0;
      end else if (s1_ff.amb == s1_ff.sgy) begin
         s2_in.k = 2'sd1;
      end else begin
         s2_in.k = -2'sd1;
      end
   end

   always_comb begin
      tu2     = 46'(s2_ff.tu) * 46'(s2_ff.tu);
      s3_in.q = dthp_pkg::Q_W'(64'sh1_0000_0000 + 64'(tu2));
      corr    = 26'((64'(s2_ff.corrp) + 64'sd8388608) >>> 24);
      diff    = 27'(s2_ff.meas) - 27'(corr);
      if (s2_ff.amb == 2'sd0) begin
         s3_in.side.part = '0;
      end else if (s2_ff.amb[1]) begin
         s3_in.side.part = -28'(diff);
      end else begin
         s3_in.side.part = 28'(diff);
      end
      s3_in.side.du = s2_ff.du;
      s3_in.side.tu = s2_ff.tu;
      s3_in.side.ca = s2_ff.ca;
      s3_in.side.sa = s2_ff.sa;
      s3_in.side.k  = s2_ff.k;
   end

   dthp_recip_sqrt u_recip (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (front_vld_ff[2]),
      .in_q      (s3_ff.q),
      .in_side   (s3_ff.side),
      .out_valid (rc_valid),
      .out_cu    (rc_cu),
      .out_side  (rc_side)
   );

   // back: products with cosU
   always_comb begin
      cus = $signed({1'b0, rc_cu});
      if (rc_side.k == 2'sd1) begin
         rterm = 48'($signed({1'b0, csr_delay_ratio_ff, 21'b0}));
      end else if (rc_side.k == -2'sd1) begin
         rterm = -48'($signed({1'b0, csr_delay_ratio_ff, 21'b0}));
      end else begin
         rterm = '0;
      end
      r1_in.cu2p = 62'(rc_cu) * 62'(rc_cu);
      r1_in.wdp  = 58'(rc_side.du) * 58'(cus);
      r1_in.hxp  = 48'(rc_side.ca) * 48'(cus);
      r1_in.hyp  = 48'(rc_side.sa) * 48'(cus) - rterm;
      r1_in.cu   = rc_cu;
      r1_in.tu   = rc_side.tu;
      r1_in.du   = rc_side.du;
      r1_in.ca   = rc_side.ca;
      r1_in.sa   = rc_side.sa;
      r1_in.part = rc_side.part;
   end

   always_comb begin
      cu2        = 31'((r1_ff.cu2p + 62'd536870912) >> 30);
      r2_in.cu3p = 62'(cu2) * 62'(r1_ff.cu);
      r2_in.tu   = r1_ff.tu;
      r2_in.du   = r1_ff.du;
      r2_in.ca   = r1_ff.ca;
      r2_in.sa   = r1_ff.sa;
      r2_in.res  = sat24(64'(r1_ff.part) - ((64'(r1_ff.wdp) + 64'sd536870912) >>> 30));
      r2_in.hx   = sat16((64'(r1_ff.hxp) + 64'sd536870912) >>> 30);
      r2_in.hy   = sat16((64'(r1_ff.hyp) + 64'sd536870912) >>> 30);
   end

   always_comb begin
      cu3        = 31'((r2_ff.cu3p + 62'd536870912) >> 30);
      r3_in.tucp = 54'(r2_ff.tu) * 54'($signed({1'b0, cu3}));
      r3_in.du   = r2_ff.du;
      r3_in.ca   = r2_ff.ca;
      r3_in.sa   = r2_ff.sa;
      r3_in.res  = r2_ff.res;
      r3_in.hx   = r2_ff.hx;
      r3_in.hy   = r2_ff.hy;
   end

   // du * tuc split in two partial products
   always_comb begin
      tuc        = 38'((64'(r3_ff.tucp) + 64'sd32768) >>> 16);
      r4_in.pplo = 46'(r3_ff.du) * 46'($signed({1'b0, tuc[17:0]}));
      r4_in.pphi = 47'(r3_ff.du) * 47'($signed(tuc[37:18]));
      r4_in.ca   = r3_ff.ca;
      r4_in.sa   = r3_ff.sa;
      r4_in.res  = r3_ff.res;
      r4_in.hx   = r3_ff.hx;
      r4_in.hy   = r3_ff.hy;
   end

   always_comb begin
      tp        = (64'(r4_ff.pphi) <<< 18) + 64'(r4_ff.pplo);
      r5_in.t   = 34'((tp + 64'sd536870912) >>> 30);
      r5_in.ca  = r4_ff.ca;
      r5_in.sa  = r4_ff.sa;
      r5_in.res = r4_ff.res;
      r5_in.hx  = r4_ff.hx;
      r5_in.hy  = r4_ff.hy;
   end

   always_comb begin
      r6_in.htxp = 50'(r5_ff.t) * 50'(r5_ff.ca);
      r6_in.htyp = 50'(r5_ff.t) * 50'(r5_ff.sa);
      r6_in.res  = r5_ff.res;
      r6_in.hx   = r5_ff.hx;
      r6_in.hy   = r5_ff.hy;
   end

   always_comb begin
      r7_in.htx = sat24(-((64'(r6_ff.htxp) + 64'sd16384) >>> 15));
      r7_in.hty = sat24(-((64'(r6_ff.htyp) + 64'sd16384) >>> 15));
      r7_in.res = r6_ff.res;
      r7_in.hx  = r6_ff.hx;
      r7_in.hy  = r6_ff.hy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= '{default: 1'b0};
         back_vld_ff  <= '{default: 1'b0};
      end else if (adv) begin
         front_vld_ff[0] <= req_valid;
         front_vld_ff[1] <= front_vld_ff[0];
         front_vld_ff[2] <= front_vld_ff[1];
         back_vld_ff[0]  <= rc_valid;
         for (int i = 1; i < 7; i++) begin
            back_vld_ff[i] <= back_vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         r1_ff <= r1_in;
         r2_ff <= r2_in;
         r3_ff <= r3_in;
         r4_ff <= r4_in;
         r5_ff <= r5_in;
         r6_ff <= r6_in;
         r7_ff <= r7_in;
      end
   end

   assign rsp_valid     = back_vld_ff[6];
   assign rsp_residual  = r7_ff.res;
   assign rsp_h_pos_x   = r7_ff.hx;
   assign rsp_h_pos_y   = r7_ff.hy;
   assign rsp_h_slope_x = r7_ff.htx;
   assign rsp_h_slope_y = r7_ff.hty;

endmodule

/* src/dthp_recip_sqrt.sv */
// Pipelined cosU = floor(2^56 / isqrt(q << 20)), one result bit per stage.
`timescale 1ns / 1ps

module dthp_recip_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic [dthp_pkg::Q_W-1:0]      in_q,
   input  dthp_pkg::side_type            in_side,
   output logic                          out_valid,
   output logic [dthp_pkg::CU_W-1:0]     out_cu,
   output dthp_pkg::side_type            out_side
);

   localparam logic [31:0] REM_INIT = 32'h0200_0000;  // 2^56 >> 31

   logic [63:0]               sq_v_ff    [0:dthp_pkg::SQRT_STEPS-1];
   logic [63:0]               sq_res_ff  [0:dthp_pkg::SQRT_STEPS-1];
   logic                      sq_vld_ff  [0:dthp_pkg::SQRT_STEPS-1];
   dthp_pkg::side_type        sq_side_ff [0:dthp_pkg::SQRT_STEPS-1];

   logic [31:0]               dv_rem_ff  [0:dthp_pkg::DIV_STEPS-1];
   logic [dthp_pkg::CU_W-1:0] dv_quo_ff  [0:dthp_pkg::DIV_STEPS-1];
   logic [31:0]               dv_r_ff    [0:dthp_pkg::DIV_STEPS-1];
   logic                      dv_vld_ff  [0:dthp_pkg::DIV_STEPS-1];
   dthp_pkg::side_type        dv_side_ff [0:dthp_pkg::DIV_STEPS-1];

   for (genvar k = 0; k < dthp_pkg::SQRT_STEPS; k++) begin : g_sqrt
      logic [63:0]        v_prev, res_prev, bit_val, trial, v_in, res_in;
      logic               vld_prev;
      dthp_pkg::side_type side_prev;

      if (k == 0) begin : g_head
         assign v_prev    = {in_q, 20'b0};
         assign res_prev  = 64'h0;
         assign vld_prev  = in_valid;
         assign side_prev = in_side;
      end else begin : g_body
         assign v_prev    = sq_v_ff[k-1];
         assign res_prev  = sq_res_ff[k-1];
         assign vld_prev  = sq_vld_ff[k-1];
         assign side_prev = sq_side_ff[k-1];
      end

      assign bit_val = 64'h1 << (62 - 2 * k);
      assign trial   = res_prev + bit_val;

      always_comb begin
         if (v_prev >= trial) begin
            v_in   = v_prev - trial;
            res_in = (res_prev >> 1) + bit_val;
         end else begin
            v_in   = v_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k] <= 1'b0;
         end else if (enable) begin
            sq_vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            sq_v_ff[k]    <= v_in;
            sq_res_ff[k]  <= res_in;
            sq_side_ff[k] <= side_prev;
         end
      end
   end

   for (genvar k = 0; k < dthp_pkg::DIV_STEPS; k++) begin : g_div
      logic [31:0]               rem_prev, r_prev, rem_in;
      logic [dthp_pkg::CU_W-1:0] quo_prev, quo_in;
      logic [32:0]               rem2;
      logic                      qbit;
      logic                      vld_prev;
      dthp_pkg::side_type        side_prev;

      if (k == 0) begin : g_head
         assign rem_prev  = REM_INIT;
         assign quo_prev  = '0;
         assign r_prev    = sq_res_ff[dthp_pkg::SQRT_STEPS-1][dthp_pkg::ROOT_W-1:0];
         assign vld_prev  = sq_vld_ff[dthp_pkg::SQRT_STEPS-1];
         assign side_prev = sq_side_ff[dthp_pkg::SQRT_STEPS-1];
      end else begin : g_body
         assign rem_prev  = dv_rem_ff[k-1];
         assign quo_prev  = dv_quo_ff[k-1];
         assign r_prev    = dv_r_ff[k-1];
         assign vld_prev  = dv_vld_ff[k-1];
         assign side_prev = dv_side_ff[k-1];
      end

      assign rem2 = {rem_prev, 1'b0};

      always_comb begin
         if (rem2 >= {1'b0, r_prev}) begin
            rem_in = 32'(rem2 - {1'b0, r_prev});
            qbit   = 1'b1;
         end else begin
            rem_in = rem2[31:0];
            qbit   = 1'b0;
         end
         quo_in = {quo_prev[dthp_pkg::CU_W-2:0], qbit};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else if (enable) begin
            dv_vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            dv_rem_ff[k]  <= rem_in;
            dv_quo_ff[k]  <= quo_in;
            dv_r_ff[k]    <= r_prev;
            dv_side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = dv_vld_ff[dthp_pkg::DIV_STEPS-1];
   assign out_cu    = dv_quo_ff[dthp_pkg::DIV_STEPS-1];
   assign out_side  = dv_side_ff[dthp_pkg::DIV_STEPS-1];

endmodule

/* src/dthp_checker.sv */
// Port-level checks for the drift-tube hit projection block, with bind.
`timescale 1ns / 1ps

module dthp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [23:0] rsp_residual,
   input logic signed [15:0] rsp_h_pos_x
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before accept");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_residual) && $stable(rsp_h_pos_x))
      else $error("stalled result beat changed");

   a_no_block: assert property (@(posedge clock)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat out of reset");

endmodule

bind drift_tube_hit_projection dthp_checker u_dthp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_residual (rsp_residual),
   .rsp_h_pos_x  (rsp_h_pos_x)
);
